// File: design/pss_pkg.sv
// Shared types, constants and helpers for the pneumatic shot sequencer.
package pss_pkg;

    // Width of the dwell counter.
    localparam int TICK_BITS = 16;
    localparam int HOLD_BITS = 16;
    localparam int DZ_BITS   = 10;
    localparam int MV_BITS   = 13;
    localparam int STICK_BITS = 11;
    localparam int CODE_BITS = 2;
    localparam int CFG_ADDR_BITS = 8;
    localparam int CFG_DATA_BITS = 16;
    localparam int CMP_BITS = (TICK_BITS > HOLD_BITS) ? TICK_BITS : HOLD_BITS;

    localparam logic [TICK_BITS-1:0] DWELL_MAX = {TICK_BITS{1'b1}};
    localparam logic [MV_BITS-1:0]   MV_MAX    = MV_BITS'(5000);

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_PRIME_HOLD  = 8'd0,
        REG_FIRE_HOLD   = 8'd1,
        REG_BACK_HOLD   = 8'd2,
        REG_DEADZONE    = 8'd3,
        REG_CHARGE_MV   = 8'd4,
        REG_AUTO_CODE   = 8'd5,
        REG_MANUAL_CODE = 8'd6,
        REG_FIRE_CODE   = 8'd7
    } pss_reg_idx_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PRIME = 2'd1,
        PH_FIRE  = 2'd2,
        PH_BACK  = 2'd3
    } pss_phase_t;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_AUTO   = 2'd1,
        MODE_MANUAL = 2'd2
    } pss_mode_t;

    typedef struct packed {
        logic [HOLD_BITS-1:0] prime_periods;
        logic [HOLD_BITS-1:0] cut_periods;
        logic [HOLD_BITS-1:0] recharge_periods;
        logic [DZ_BITS-1:0]   stick_deadzone;
        logic [MV_BITS-1:0]   charge_millivolts;
        logic [CODE_BITS-1:0] auto_switch_code;
        logic [CODE_BITS-1:0] manual_switch_code;
        logic [CODE_BITS-1:0] fire_switch_code;
    } pss_cfg_t;

    typedef struct packed {
        logic signed [STICK_BITS-1:0] stick_x;
        logic                         ball_present;
        logic [CODE_BITS-1:0]         fire_switch;
        logic [CODE_BITS-1:0]         mode_switch;
    } pss_item_t;

    typedef struct packed {
        pss_phase_t         phase_now;
        pss_mode_t          mode_now;
        logic [MV_BITS-1:0] valve_millivolts;
        logic               valve_out;
        logic               pusher_out;
    } pss_result_t;

    // True once the dwell count has reached the hold count.
    function automatic logic hold_done(input logic [TICK_BITS-1:0] dwell,
                                       input logic [HOLD_BITS-1:0] hold);
        return CMP_BITS'(dwell) >= CMP_BITS'(hold);
    endfunction

endpackage

// File: design/pss_cfg_regs.sv
// Configuration register file of the shot sequencer.
module pss_cfg_regs
    import pss_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    output pss_cfg_t                 cfg
);

    pss_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prime_periods      <= HOLD_BITS'(40);
            cfg_reg.cut_periods        <= HOLD_BITS'(40);
            cfg_reg.recharge_periods   <= HOLD_BITS'(40);
            cfg_reg.stick_deadzone     <= DZ_BITS'(300);
            cfg_reg.charge_millivolts  <= MV_BITS'(2500);
            cfg_reg.auto_switch_code   <= CODE_BITS'(1);
            cfg_reg.manual_switch_code <= CODE_BITS'(3);
            cfg_reg.fire_switch_code   <= CODE_BITS'(2);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_PRIME_HOLD:  cfg_reg.prime_periods      <= cfg_wdata[HOLD_BITS-1:0];
                REG_FIRE_HOLD:   cfg_reg.cut_periods        <= cfg_wdata[HOLD_BITS-1:0];
                REG_BACK_HOLD:   cfg_reg.recharge_periods   <= cfg_wdata[HOLD_BITS-1:0];
                REG_DEADZONE:    cfg_reg.stick_deadzone     <= cfg_wdata[DZ_BITS-1:0];
                REG_CHARGE_MV:   cfg_reg.charge_millivolts  <= cfg_wdata[MV_BITS-1:0];
                REG_AUTO_CODE:   cfg_reg.auto_switch_code   <= cfg_wdata[CODE_BITS-1:0];
                REG_MANUAL_CODE: cfg_reg.manual_switch_code <= cfg_wdata[CODE_BITS-1:0];
                REG_FIRE_CODE:   cfg_reg.fire_switch_code   <= cfg_wdata[CODE_BITS-1:0];
                default: ;  // Unmapped index: the write is dropped.
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/pss_seq.sv
// Sequencer state and the per-period next-state and output logic.
module pss_seq
    import pss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step_en,
    input  pss_item_t   item,
    input  pss_cfg_t    cfg,
    output pss_result_t result
);

    pss_phase_t           phase_reg, phase_next;
    logic [TICK_BITS-1:0] dwell_reg, dwell_next;
    logic [CODE_BITS-1:0] prev_fire_reg;
    logic                 pending_reg, pending_next;
    logic                 pusher_reg, pusher_next;
    logic [HOLD_BITS-1:0] countdown_reg, countdown_next;

    logic [TICK_BITS-1:0] dwell_inc;
    logic                 pending_in;
    pss_mode_t            mode;
    pss_phase_t           phase_sel;
    logic [HOLD_BITS-1:0] countdown_ld;
    logic [MV_BITS-1:0]   mv_sat;
    logic signed [DZ_BITS+1:0] sx_ext, dz_pos, dz_neg;

    always_comb begin
        dwell_inc  = (dwell_reg == DWELL_MAX) ? dwell_reg : dwell_reg + 1'b1;
        mv_sat     = (cfg.charge_millivolts > MV_MAX) ? MV_MAX : cfg.charge_millivolts;
        sx_ext     = (DZ_BITS+2)'(item.stick_x);
        dz_pos     = $signed({2'b00, cfg.stick_deadzone});
        dz_neg     = -dz_pos;
        pending_in = pending_reg ||
                     ((item.fire_switch == cfg.fire_switch_code) &&
                      (prev_fire_reg != cfg.fire_switch_code));

        // Auto takes precedence when both codes match.
        if (item.mode_switch == cfg.auto_switch_code) begin
            mode = MODE_AUTO;
        end else if (item.mode_switch == cfg.manual_switch_code) begin
            mode = MODE_MANUAL;
        end else begin
            mode = MODE_OFF;
        end

        phase_sel      = PH_IDLE;
        pending_next   = pending_in;
        pusher_next    = pusher_reg;
        countdown_next = countdown_reg;
        countdown_ld   = countdown_reg;
        result.pusher_out       = 1'b0;
        result.valve_out        = 1'b0;
        result.valve_millivolts = '0;

        unique case (mode)
            MODE_AUTO: begin
                phase_sel = phase_reg;
                unique case (phase_reg)
                    PH_IDLE: begin
                        if (item.ball_present) begin
                            phase_sel = PH_PRIME;
                        end
                    end
                    PH_PRIME: begin
                        if (hold_done(dwell_inc, cfg.prime_periods) && pending_in) begin
                            pending_next = 1'b0;
                            phase_sel    = PH_FIRE;
                        end
                    end
                    PH_FIRE: begin
                        if (hold_done(dwell_inc, cfg.cut_periods)) begin
                            phase_sel = PH_BACK;
                        end
                    end
                    PH_BACK: begin
                        if (hold_done(dwell_inc, cfg.recharge_periods)) begin
                            phase_sel = PH_IDLE;
                        end
                    end
                endcase
                pusher_next = (phase_sel == PH_PRIME);
                unique case (phase_sel)
                    PH_IDLE: begin
                        result.valve_out        = 1'b1;
                        result.valve_millivolts = mv_sat;
                    end
                    PH_FIRE: begin
                        result.pusher_out = 1'b1;
                    end
                    PH_PRIME, PH_BACK: begin
                        result.pusher_out       = 1'b1;
                        result.valve_out        = 1'b1;
                        result.valve_millivolts = mv_sat;
                    end
                endcase
            end
            MODE_MANUAL: begin
                if (sx_ext > dz_pos) begin
                    pusher_next = 1'b1;
                end else if (sx_ext < dz_neg) begin
                    pusher_next = 1'b0;
                end
                // A pending shot is consumed here and arms the valve cut.
                pending_next = 1'b0;
                countdown_ld = pending_in ? cfg.cut_periods : countdown_reg;
                result.pusher_out = pusher_next;
                if (countdown_ld != '0) begin
                    countdown_next = countdown_ld - 1'b1;
                end else begin
                    countdown_next          = countdown_ld;
                    result.valve_out        = 1'b1;
                    result.valve_millivolts = mv_sat;
                end
            end
            MODE_OFF: begin
                pending_next = 1'b0;
                pusher_next  = 1'b0;
            end
            default: ;
        endcase

        phase_next = phase_sel;
        dwell_next = (phase_sel != phase_reg) ? '0 : dwell_inc;

        result.mode_now  = mode;
        // Off reports all-zero outputs, including the phase.
        result.phase_now = phase_sel;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            dwell_reg     <= '0;
            prev_fire_reg <= CODE_BITS'(2);
            pending_reg   <= 1'b0;
            pusher_reg    <= 1'b0;
            countdown_reg <= '0;
        end else if (step_en) begin
            phase_reg     <= phase_next;
            dwell_reg     <= dwell_next;
            prev_fire_reg <= item.fire_switch;
            pending_reg   <= pending_next;
            pusher_reg    <= pusher_next;
            countdown_reg <= countdown_next;
        end
    end

endmodule

// File: design/pneumatic_shot_sequencer_core.sv
// Top level of the pneumatic shot sequencer: stream handshake and result register.
//
// Each request on the s_ channel is one control period: mode switch, fire switch,
// ball sensor and stick X. For every request the block returns exactly one result
// request on the m_ channel with the pusher, valve, valve voltage, decoded mode and
// sequence phase. Results come out in request order.
//
// After the accepting edge the request sits in the input register while the sequencer
// logic evaluates it against the held state; the edge on which it advances loads the
// result register and raises m_tvalid. Throughput is one request per cycle while m_
// is not stalled, because the sequencer state updates on that same edge.
//
// The input register accepts a new request while a finished result waits on m_, so
// a stalled receiver costs at most one extra slot before s_tready drops. While a result
// waits on m_ with m_tready low, the result and the sequencer state hold.
//
// aresetn is synchronous and active low: it empties both registers, returns the
// sequence to idle, clears the pending shot, the pusher and the manual countdown,
// and loads the default register values. Configuration writes take effect at the
// clock edge on which cfg_wr_en is high; write only while the block is idle.
module pneumatic_shot_sequencer_core
    import pss_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // Configuration write port.
    input  logic                     cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    // Input stream.
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // s_tdata: mode_switch[1:0], fire_switch[3:2], ball_present[4], stick_x[15:5]
    input  logic [15:0]              s_tdata,
    // Result stream.
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // m_tdata: pusher_out[0], valve_out[1], valve_millivolts[14:2],
    // mode_now[16:15], phase_now[18:17], zero fill [23:19]
    output logic [23:0]              m_tdata
);

    pss_cfg_t    cfg;
    pss_item_t   item_reg;
    logic        in_valid_reg;
    pss_result_t step_result;
    pss_result_t result_reg;
    logic        out_valid_reg;
    logic        advance;

    pss_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The held request moves on whenever the result slot is free or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    pss_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= pss_item_t'(s_tdata);
        end
        if (advance) begin
            result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, result_reg};

endmodule

// File: design/pss_checker.sv
// Port-level checker for the shot sequencer, bound to the top level.
module pss_checker
    import pss_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_off_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[16:15] == MODE_OFF) |->
            (m_tdata[14:0] == 15'd0) && (m_tdata[18:17] == PH_IDLE))
        else $error("actuator active in off mode");

    a_manual_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[16:15] == MODE_MANUAL) |-> (m_tdata[18:17] == PH_IDLE))
        else $error("phase not idle in manual mode");

    a_mv_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[14:2] <= MV_MAX))
        else $error("valve voltage above limit");

    a_closed_no_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[1] |-> (m_tdata[14:2] == '0))
        else $error("valve voltage driven while valve closed");

endmodule

bind pneumatic_shot_sequencer_core pss_checker u_pss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
